// ===== hw/rtl/rounding_integer_divider_core_defines.svh =====
// Assertion macros shared by the divider RTL.
`ifndef ROUNDING_INTEGER_DIVIDER_CORE_DEFINES_SVH
`define ROUNDING_INTEGER_DIVIDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define RDIV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RDIV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RDIV_ASSERT(lbl, clk, rst_n, prop, msg)

`define RDIV_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/rdiv_pkg.sv =====
package rdiv_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FIELD_W = 32;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ROUND_MODE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SIGNED = 8'd1;

	typedef enum logic [1:0] {
		RM_TRUNC     = 2'd0,
		RM_NEAR_TZ   = 2'd1,
		RM_NEAR_AWAY = 2'd2
	} round_mode_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_DIV_NEG  = 2'd2
	} err_code_t;

endpackage

// ===== hw/rtl/rounding_integer_divider_core.sv =====
// An item passes the entry register, the restoring stages, the rounding and output registers.
// One item per cycle unless stalled; each quotient bit has its own restoring subtract stage.
// The output handshake freezes the whole pipeline while a result is stalled.
// Reset (arst_n low, asynchronous) clears every valid bit, sets round_mode to truncate
// and signed_operands to two's complement.
`include "rounding_integer_divider_core_defines.svh"

module rounding_integer_divider_core #(
	parameter int DATA_WIDTH = rdiv_pkg::DATA_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [rdiv_pkg::FIELD_W-1:0]        dividend,
	input  logic [rdiv_pkg::FIELD_W-1:0]        divisor,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [rdiv_pkg::FIELD_W-1:0]        quotient,
	output rdiv_pkg::err_code_t                 error_code,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rdiv_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rdiv_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DW = DATA_WIDTH;
	localparam int FW = rdiv_pkg::FIELD_W;

	typedef struct packed {
		logic [DW-1:0]       rem;
		logic [DW-1:0]       quo;
		logic [DW-1:0]       dvs;
		logic                neg;
		rdiv_pkg::err_code_t err;
		logic [1:0]          mode;
	} div_stage_t;

	logic [1:0] round_mode_q;
	logic       signed_q;

	logic adv;

	logic [DW-1:0]       n_in;
	logic [DW-1:0]       d_in;
	logic                neg_in;
	rdiv_pkg::err_code_t err_in;
	div_stage_t          entry;

	div_stage_t div_s     [0:DW];
	logic       div_vld_s [0:DW];
	div_stage_t div_next  [1:DW];

	logic [DW:0]         twice_rem;
	logic                rem_gt_half;
	logic                rem_ge_half;
	logic                round_up;

	logic                rnd_vld_s;
	logic [DW-1:0]       rnd_quo_s;
	logic                rnd_neg_s;
	rdiv_pkg::err_code_t rnd_err_s;

	logic [DW-1:0]       out_quo_s;
	rdiv_pkg::err_code_t out_err_s;
	logic                out_vld_s;

	// Configuration.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_mode_q <= rdiv_pkg::RM_TRUNC;
			signed_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rdiv_pkg::CFG_IDX_ROUND_MODE) begin
				round_mode_q <= cfg_data[1:0];
			end else if (cfg_index == rdiv_pkg::CFG_IDX_SIGNED) begin
				signed_q <= cfg_data[0];
			end
		end
	end

	// The pipeline moves as a whole unless a finished result is held.
	assign adv = !(out_vld_s && result_stall);
	assign item_stall = !adv;

	// Operand fitting: low DW bits of each field, zero extended past the field width.
	generate
		if (DW > FW) begin : g_wide_in
			assign n_in = {{(DW-FW){1'b0}}, dividend};
			assign d_in = {{(DW-FW){1'b0}}, divisor};
		end else begin : g_narrow_in
			assign n_in = dividend[DW-1:0];
			assign d_in = divisor[DW-1:0];
		end
	endgenerate

	always_comb begin
		if (d_in == '0) begin
			err_in = rdiv_pkg::ERR_DIV_ZERO;
		end else if (signed_q && d_in[DW-1]) begin
			err_in = rdiv_pkg::ERR_DIV_NEG;
		end else begin
			err_in = rdiv_pkg::ERR_OK;
		end
		neg_in = signed_q && n_in[DW-1];
		entry.rem = '0;
		// Negating the most negative value wraps to its correct unsigned magnitude.
		entry.quo = neg_in ? (~n_in + {{(DW-1){1'b0}}, 1'b1}) : n_in;
		entry.dvs = d_in;
		entry.neg = neg_in;
		entry.err = err_in;
		entry.mode = round_mode_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= entry;
		end
	end

	// One restoring step per stage: the quotient register shifts dividend bits
	// out at the top and quotient bits in at the bottom.
	genvar k;
	generate
		for (k = 1; k <= DW; k++) begin : g_step
			logic [DW:0] trial;
			logic [DW:0] diff;
			logic        ge;

			assign trial = {div_s[k-1].rem, div_s[k-1].quo[DW-1]};
			assign diff = trial - {1'b0, div_s[k-1].dvs};
			assign ge = !diff[DW];

			always_comb begin
				div_next[k] = div_s[k-1];
				div_next[k].rem = ge ? diff[DW-1:0] : trial[DW-1:0];
				div_next[k].quo = {div_s[k-1].quo[DW-2:0], ge};
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_vld_s[k] <= 1'b0;
				end else if (adv) begin
					div_vld_s[k] <= div_vld_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					div_s[k] <= div_next[k];
				end
			end
		end
	endgenerate

	// Rounding: r > floor(d/2) is 2r > d, and r >= ceil(d/2) is 2r >= d.
	assign twice_rem = {div_s[DW].rem, 1'b0};
	assign rem_gt_half = twice_rem > {1'b0, div_s[DW].dvs};
	assign rem_ge_half = twice_rem >= {1'b0, div_s[DW].dvs};

	always_comb begin
		case (div_s[DW].mode)
			rdiv_pkg::RM_NEAR_TZ:   round_up = rem_gt_half;
			rdiv_pkg::RM_NEAR_AWAY: round_up = rem_ge_half;
			default:                round_up = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_vld_s <= 1'b0;
		end else if (adv) begin
			rnd_vld_s <= div_vld_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rnd_quo_s <= div_s[DW].quo + {{(DW-1){1'b0}}, round_up};
			rnd_neg_s <= div_s[DW].neg;
			rnd_err_s <= div_s[DW].err;
		end
	end

	// Sign restore and error forcing into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s <= 1'b0;
		end else if (adv) begin
			out_vld_s <= rnd_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rnd_err_s != rdiv_pkg::ERR_OK) begin
				out_quo_s <= '0;
			end else if (rnd_neg_s) begin
				out_quo_s <= ~rnd_quo_s + {{(DW-1){1'b0}}, 1'b1};
			end else begin
				out_quo_s <= rnd_quo_s;
			end
			out_err_s <= rnd_err_s;
		end
	end

	assign result_valid = out_vld_s;
	assign error_code = out_err_s;

	generate
		if (DW >= FW) begin : g_wide_out
			assign quotient = out_quo_s[FW-1:0];
		end else begin : g_narrow_out
			assign quotient = {{(FW-DW){1'b0}}, out_quo_s};
		end
	endgenerate

	`RDIV_ASSERT(a_err_zero_quo, clk, arst_n, (out_vld_s && out_err_s != rdiv_pkg::ERR_OK) |-> (out_quo_s == '0), "error result carries a nonzero quotient")

	`RDIV_ASSERT(a_err_code_legal, clk, arst_n, out_vld_s |-> (out_err_s == rdiv_pkg::ERR_OK || out_err_s == rdiv_pkg::ERR_DIV_ZERO || out_err_s == rdiv_pkg::ERR_DIV_NEG), "result carries an undefined error code")

	`RDIV_ASSERT(a_rem_below_dvs, clk, arst_n, (div_vld_s[DW] && div_s[DW].err == rdiv_pkg::ERR_OK) |-> (div_s[DW].rem < div_s[DW].dvs), "final remainder is not below the divisor")

	`RDIV_ASSERT(a_hold_last_stage, clk, arst_n, !adv |=> ($stable(div_vld_s[DW]) && $stable(rnd_vld_s)), "pipeline moved while the output was held")

	`RDIV_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> (!out_vld_s && !rnd_vld_s), "pipeline holds a valid item in reset")

endmodule

// ===== dv/tb.sv =====
module tb;
	import rdiv_pkg::*;

	localparam int LATENCY = DATA_WIDTH + 2;
	localparam logic [1:0] RM_UNUSED = 2'd3;
	localparam int PHASES = 24;
	localparam int RANDOM_ITEMS = 1800;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TOP = {CFG_INDEX_W{1'b1}};

	// Directed operand pairs: {dividend, divisor}.
	localparam logic [63:0] DIRECTED [20] = '{
		{32'h0000_0007, 32'h0000_0002}, {32'hFFFF_FFF9, 32'h0000_0002},
		{32'h0000_0005, 32'h0000_0000}, {32'h0000_0000, 32'h0000_0000},
		{32'h0000_0005, 32'h8000_0000}, {32'hFFFF_FFFF, 32'hFFFF_FFFF},
		{32'h8000_0000, 32'h0000_0001}, {32'h8000_0000, 32'h7FFF_FFFF},
		{32'h8000_0000, 32'h0000_0002}, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
		{32'h7FFF_FFFF, 32'h0000_0001}, {32'hFFFF_FFFF, 32'h0000_0001},
		{32'h0000_0000, 32'h0000_0001}, {32'h0000_000A, 32'h0000_0004},
		{32'h0000_000B, 32'h0000_0004}, {32'h0000_0009, 32'h0000_0004},
		{32'h0000_0001, 32'h0000_0003}, {32'h0000_0002, 32'h0000_0003},
		{32'hFFFF_FFFE, 32'h0000_0003}, {32'h7FFF_FFFF, 32'hFFFF_FFFE}
	};

	typedef struct packed {
		logic [FIELD_W-1:0] quotient;
		err_code_t err;
	} quot_t;

	class quotient_board;
		logic [1:0] round_mode;
		bit signed_ops;
		quot_t awaited[$];
		int mismatches;

		function new();
			round_mode = RM_TRUNC;
			signed_ops = 1'b1;
			mismatches = 0;
		endfunction

		function void apply_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == CFG_IDX_ROUND_MODE)
				round_mode = data[1:0];
			else if (index == CFG_IDX_SIGNED)
				signed_ops = data[0];
		endfunction

		// Divides magnitudes, rounds the magnitude, then restores the sign.
		function void note_operands(logic [FIELD_W-1:0] num, logic [FIELD_W-1:0] den);
			logic [DATA_WIDTH-1:0] n, d, mag, q, r, half_down, half_up;
			logic neg;
			quot_t res;
			n = DATA_WIDTH'(num);
			d = DATA_WIDTH'(den);
			res.quotient = '0;
			res.err = ERR_OK;
			if (d == '0) begin
				res.err = ERR_DIV_ZERO;
			end else if (signed_ops && d[DATA_WIDTH-1]) begin
				res.err = ERR_DIV_NEG;
			end else begin
				neg = signed_ops && n[DATA_WIDTH-1];
				mag = neg ? -n : n;
				q = mag / d;
				r = mag % d;
				half_down = d >> 1;
				half_up = d - half_down;
				if (round_mode == RM_NEAR_TZ && r > half_down)
					q = q + 1'b1;
				else if (round_mode == RM_NEAR_AWAY && r >= half_up)
					q = q + 1'b1;
				if (neg)
					q = -q;
				res.quotient = FIELD_W'(q);
			end
			awaited.push_back(res);
		endfunction

		function void check_quotient(logic [FIELD_W-1:0] q, err_code_t e);
			quot_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: quotient %h error %0d", q, e);
				return;
			end
			want = awaited.pop_front();
			if (q !== want.quotient || e !== want.err) begin
				mismatches++;
				if (mismatches <= 10)
					$display("quotient mismatch: expected %h err %0d, got %h err %0d",
						want.quotient, want.err, q, e);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [FIELD_W-1:0] dividend = '0;
	logic [FIELD_W-1:0] divisor = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [FIELD_W-1:0] quotient;
	err_code_t error_code;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit quiet = 1'b0;
	quotient_board board = new();

	rounding_integer_divider_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.dividend(dividend),
		.divisor(divisor),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.quotient(quotient),
		.error_code(error_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Mostly short gaps, now and then a long one; none in quiet phases.
	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				result_stall <= 1'b1;
				hold--;
			end else begin
				result_stall <= 1'b0;
				hold = pick_gap();
			end
		end
	end

	// Outputs are stable from the falling edge up to the rising edge that accepts the item.
	always @(negedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_quotient(quotient, error_code);
	end

	task automatic send_item(input logic [FIELD_W-1:0] num, input logic [FIELD_W-1:0] den);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		dividend <= num;
		divisor <= den;
		do @(negedge clk); while (item_stall);
		@(posedge clk);
		board.note_operands(num, den);
	endtask

	task automatic send_random();
		logic [FIELD_W-1:0] num, den, quo, rem;
		int pick, w;
		pick = $urandom_range(0, 9);
		w = $urandom_range(1, FIELD_W - 1);
		den = $urandom & ((32'd1 << w) - 1);
		if (den == '0)
			den = 1;
		num = $urandom;
		case (pick)
		0: den = $urandom;
		1: den = '0;
		2: den = $urandom | (32'd1 << (FIELD_W - 1));
		3, 4, 5: begin
			// Remainders at and around half the divisor exercise the tie rules.
			quo = $urandom_range(0, 32'h7FFF_FFFF / den);
			case ($urandom_range(0, 5))
			0: rem = den >> 1;
			1: rem = den - (den >> 1);
			2: rem = (den >> 1) - 1;
			3: rem = (den >> 1) + 1;
			4: rem = den - 1;
			default: rem = '0;
			endcase
			if (rem >= den)
				rem = '0;
			num = quo * den + rem;
			if ($urandom_range(0, 1))
				num = -num;
		end
		6: begin
			case ($urandom_range(0, 3))
			0: num = 32'h8000_0000;
			1: num = 32'h7FFF_FFFF;
			2: num = 32'hFFFF_FFFF;
			default: num = '0;
			endcase
		end
		default: ;
		endcase
		send_item(num, den);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		board.apply_reg(index, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	initial begin
		logic [1:0] mode_list [4];
		logic [1:0] mode;
		logic sgn;
		// A falling edge at time zero clears the block before the first clock edge.
		arst_n <= 1'b0;
		mode_list = '{RM_TRUNC, RM_NEAR_TZ, RM_NEAR_AWAY, RM_UNUSED};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed items run under the reset settings.
		foreach (DIRECTED[i])
			send_item(DIRECTED[i][63:32], DIRECTED[i][31:0]);
		item_valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			if (p < 16) begin
				mode = mode_list[p % 4];
				sgn = 1'((p / 4) % 2);
			end else begin
				mode = mode_list[$urandom_range(0, 3)];
				sgn = 1'($urandom_range(0, 1));
			end
			quiet = (p % 5 == 3);
			wait_idle();
			write_reg(CFG_IDX_ROUND_MODE, ($urandom & ~32'd3) | mode);
			write_reg(CFG_IDX_SIGNED, ($urandom & ~32'd1) | sgn);
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_INDEX_W'($urandom_range(CFG_IDX_SIGNED + 1, CFG_IDX_TOP)),
					$urandom);
			repeat (RANDOM_ITEMS / PHASES) send_random();
			item_valid <= 1'b0;
		end

		wait_idle();
		if (board.mismatches == 0 && board.awaited.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rdiv_pkg.sv
hw/rtl/rounding_integer_divider_core.sv
dv/tb.sv
